// ===== src/pba_pkg.sv =====
// Shared types, register indexes and arithmetic helpers of the bandwidth adaptor.
package pba_pkg;

	localparam int BW_W = 20;
	localparam int DISC_W = 24;
	localparam int TAU_W = 24;
	localparam int IDX_W = 3;
	localparam int CFG_W = 20;

	localparam logic [IDX_W-1:0] REG_ENABLE = 3'd0;
	localparam logic [IDX_W-1:0] REG_ALPHA  = 3'd1;
	localparam logic [IDX_W-1:0] REG_TLBCA  = 3'd2;
	localparam logic [IDX_W-1:0] REG_SGAIN  = 3'd3;
	localparam logic [IDX_W-1:0] REG_DELTA  = 3'd4;
	localparam logic [IDX_W-1:0] REG_BWMIN  = 3'd5;
	localparam logic [IDX_W-1:0] REG_BWMAX  = 3'd6;
	localparam logic [IDX_W-1:0] REG_WARM   = 3'd7;

	localparam logic [16:0] Q16_ONE = 17'h10000;

	typedef struct packed {
		logic        enable;
		logic [16:0] alpha;
		logic [16:0] tl;
		logic [19:0] sgain;
		logic [19:0] delta;
		logic [19:0] bwmin;
		logic [19:0] bwmax;
		logic [15:0] warm;
	} cfg_t;

	typedef struct packed {
		logic                     dis;
		logic signed [DISC_W-1:0] disc;
		logic [BW_W-1:0]          bw;
		logic [TAU_W-1:0]         tau;
	} item_t;

	// Piecewise-linear sigmoid for a non-negative Q16 argument.
	function automatic logic [16:0] plan_pos(input logic [35:0] y);
		logic [35:0] r;
		begin
			if (y >= 36'd327680)
				r = 36'd65536;
			else if (y >= 36'd155648)
				r = (y >> 5) + 36'd55296;
			else if (y >= 36'd65536)
				r = (y >> 3) + 36'd40960;
			else
				r = (y >> 2) + 36'd32768;
			return r[16:0];
		end
	endfunction

	// Mirror the positive half for negative arguments.
	function automatic logic [16:0] plan_sig(input logic signed [35:0] x);
		logic [35:0] mag;
		begin
			mag = 36'(-x);
			if (x < 0)
				return Q16_ONE - plan_pos(mag);
			return plan_pos(36'(x));
		end
	endfunction

	// Clamp to [lo, hi]; crossed limits give lo.
	function automatic logic signed [23:0] clamp_bw(input logic signed [23:0] v,
		input logic [19:0] lo, input logic [19:0] hi);
		logic signed [23:0] r;
		begin
			r = v;
			if (r > $signed({4'b0, hi}))
				r = $signed({4'b0, hi});
			if (r < $signed({4'b0, lo}))
				r = $signed({4'b0, lo});
			return r;
		end
	endfunction

endpackage

// ===== src/pba_front.sv =====
// Front end: accepts items, tags disabled ones and queues them for the back end.
module pba_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 enable,
	input  logic signed [23:0]   disc_hz,
	input  logic [19:0]          current_bw,
	input  logic [23:0]          tau_int,
	input  logic                 take,
	output logic                 avail,
	output pba_pkg::item_t       head
);

	pba_pkg::item_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_push, do_take;

	assign full    = (cnt_q == 2'd2);
	assign avail   = (cnt_q != 2'd0);
	assign head    = mem_q[rp_q];
	assign do_push = push && !full;
	assign do_take = take && avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= '{dis: !enable, disc: disc_hz, bw: current_bw, tau: tau_int};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wp_q <= !wp_q;
			if (do_take)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_take);
		end
	end

endmodule

// ===== src/pba_back.sv =====
// Back end: statistics update, square root, division, sigmoids and Schmitt latch.
module pba_back (
	input  logic               clk,
	input  logic               arst_n,
	input  pba_pkg::cfg_t      cfg,
	input  logic               avail,
	input  pba_pkg::item_t     head,
	output logic               take,
	input  logic               pop,
	output logic               out_valid,
	output logic [19:0]        out_bw,
	output logic               out_warm
);

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_DEV   = 5'd1;
	localparam logic [4:0] ST_MEAN  = 5'd2;
	localparam logic [4:0] ST_QSQ   = 5'd3;
	localparam logic [4:0] ST_V1    = 5'd4;
	localparam logic [4:0] ST_V2    = 5'd5;
	localparam logic [4:0] ST_V3    = 5'd6;
	localparam logic [4:0] ST_SQRT  = 5'd7;
	localparam logic [4:0] ST_DINIT = 5'd8;
	localparam logic [4:0] ST_DIV   = 5'd9;
	localparam logic [4:0] ST_BN    = 5'd10;
	localparam logic [4:0] ST_ARG   = 5'd11;
	localparam logic [4:0] ST_SIG   = 5'd12;
	localparam logic [4:0] ST_BLEND = 5'd13;
	localparam logic [4:0] ST_GAIN  = 5'd14;
	localparam logic [4:0] ST_CLAMP = 5'd15;
	localparam logic [4:0] ST_SCHM  = 5'd16;
	localparam logic [4:0] ST_OUT   = 5'd17;

	localparam logic [5:0] SQRT_LAST = 6'd31;
	localparam logic [5:0] DIV_LAST  = 6'd16;

	logic [4:0]  st_q;
	logic [5:0]  cnt_q;
	pba_pkg::item_t it_q;

	logic signed [39:0] mean_q;
	logic [63:0] var_q;
	logic [16:0] count_q;
	logic [19:0] latch_q;

	logic signed [40:0] dev_q;
	logic [31:0] q_q;
	logic [63:0] qq_q;
	logic [64:0] ph_q;
	logic [32:0] pl_q;
	logic [63:0] t_q;
	logic [31:0] m_q;
	logic [63:0] vsh_q;
	logic [35:0] rem_q;
	logic [31:0] root_q;
	logic [32:0] den_q;
	logic [16:0] dt_q;
	logic [43:0] p_q;
	logic signed [35:0] a1_q, a2_q;
	logic [16:0] s1_q, s2_q, blend_q;
	logic [20:0] g_q, sd_q;
	logic signed [23:0] bhat_q;
	logic [19:0] res_bw_q;
	logic        res_warm_q;
	logic        oval_q;
	logic [19:0] obw_q;
	logic        owarm_q;

	logic [16:0] alpha_s, beta_s, tl_s, tlc_s;
	logic signed [58:0] mprod;
	logic [40:0] absdev;
	logic [32:0] qfull;
	logic [63:0] var_new;
	logic [16:0] count_new;
	logic [39:0] absmean;
	logic [35:0] rem_sh, trial;
	logic        ge;
	logic [35:0] rem_d;
	logic [51:0] p50, p250;
	logic [33:0] bsum;
	logic [36:0] gprod, sdprod;
	logic signed [23:0] bsig, diff, dl, nxt, nxtc;

	assign alpha_s = (cfg.alpha > pba_pkg::Q16_ONE) ? pba_pkg::Q16_ONE : cfg.alpha;
	assign beta_s  = pba_pkg::Q16_ONE - alpha_s;
	assign tl_s    = (cfg.tl > pba_pkg::Q16_ONE) ? pba_pkg::Q16_ONE : cfg.tl;
	assign tlc_s   = pba_pkg::Q16_ONE - tl_s;

	assign mprod   = $signed({1'b0, alpha_s}) * dev_q;
	assign absdev  = dev_q[40] ? 41'(-dev_q) : 41'(dev_q);
	assign qfull   = absdev[40:8];
	assign var_new = t_q + ph_q[63:0] + 64'(pl_q >> 16);
	assign count_new = (count_q == 17'h1FFFF) ? count_q : count_q + 17'd1;
	assign absmean = mean_q[39] ? 40'(-mean_q) : 40'(mean_q);

	assign rem_sh = {rem_q[33:0], vsh_q[63:62]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = (den_q != 33'd0) && (rem_q >= {3'b000, den_q});
	assign rem_d  = ge ? rem_q - {3'b000, den_q} : rem_q;

	assign p50   = 52'(p_q) * 52'd50;
	assign p250  = 52'(p_q) * 52'd250;
	assign bsum  = 34'(tl_s * s1_q) + 34'(tlc_s * s2_q);
	assign gprod = cfg.sgain * blend_q;
	assign sdprod = cfg.sgain * dt_q;

	assign bsig = $signed({4'b0, it_q.bw}) + $signed({3'b0, sd_q}) - $signed({3'b0, g_q});
	assign dl   = $signed({4'b0, latch_q});
	assign diff = bhat_q - dl;
	always_comb begin
		nxt = dl;
		if (diff > $signed({4'b0, cfg.delta}))
			nxt = dl + $signed({4'b0, cfg.delta});
		else if (diff < -$signed({4'b0, cfg.delta}))
			nxt = dl - $signed({4'b0, cfg.delta});
	end
	assign nxtc = pba_pkg::clamp_bw(nxt, cfg.bwmin, cfg.bwmax);

	assign take      = (st_q == ST_IDLE) && avail;
	assign out_valid = oval_q;
	assign out_bw    = obw_q;
	assign out_warm  = owarm_q;

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				it_q       <= head;
				res_bw_q   <= head.bw;
				res_warm_q <= 1'b1;
			end
			ST_DEV: begin
				dev_q <= 41'($signed({it_q.disc, 16'h0000})) - 41'(mean_q);
			end
			ST_MEAN: begin
				q_q <= qfull[32] ? 32'hFFFF_FFFF : qfull[31:0];
			end
			ST_QSQ: begin
				qq_q <= q_q * q_q;
			end
			ST_V1: begin
				ph_q <= alpha_s * qq_q[63:16];
				pl_q <= alpha_s * qq_q[15:0];
			end
			ST_V2: begin
				t_q  <= ph_q[63:0] + 64'(pl_q >> 16);
				ph_q <= beta_s * var_q[63:16];
				pl_q <= beta_s * var_q[15:0];
			end
			ST_V3: begin
				m_q    <= absmean[39:8];
				vsh_q  <= var_new;
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				vsh_q <= vsh_q << 2;
				if (rem_sh >= trial) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[30:0], 1'b0};
				end
			end
			ST_DINIT: begin
				den_q <= {1'b0, root_q} + {1'b0, m_q};
				rem_q <= {4'b0000, m_q};
				dt_q  <= '0;
			end
			ST_DIV: begin
				rem_q <= {rem_d[34:0], 1'b0};
				dt_q  <= {dt_q[15:0], ge};
			end
			ST_BN: begin
				p_q <= it_q.bw * it_q.tau;
			end
			ST_ARG: begin
				a1_q <= $signed({2'b00, p50[51:18]}) - 36'sd196608;
				a2_q <= $signed({2'b00, p250[51:18]}) - 36'sd5898240;
			end
			ST_SIG: begin
				s1_q <= pba_pkg::plan_sig(a1_q);
				s2_q <= pba_pkg::plan_sig(a2_q);
			end
			ST_BLEND: begin
				blend_q <= bsum[32:16];
			end
			ST_GAIN: begin
				g_q  <= gprod[36:16];
				sd_q <= sdprod[36:16];
			end
			ST_CLAMP: begin
				bhat_q <= pba_pkg::clamp_bw(bsig, cfg.bwmin, cfg.bwmax);
			end
			ST_SCHM: begin
				res_bw_q   <= nxtc[19:0];
				res_warm_q <= 1'b0;
			end
			ST_OUT: begin
			end
			default: begin
			end
		endcase
		if (st_q == ST_OUT && (!oval_q || pop)) begin
			obw_q   <= res_bw_q;
			owarm_q <= res_warm_q;
		end
	end

	// Sequencer, loop state and result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			cnt_q   <= '0;
			mean_q  <= '0;
			var_q   <= '0;
			count_q <= '0;
			latch_q <= '0;
			oval_q  <= 1'b0;
		end else begin
			if (st_q == ST_OUT && (!oval_q || pop))
				oval_q <= 1'b1;
			else if (pop && oval_q)
				oval_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (avail)
						st_q <= head.dis ? ST_OUT : ST_DEV;
				end
				ST_DEV:  st_q <= ST_MEAN;
				ST_MEAN: begin
					mean_q <= mean_q + 40'(mprod >>> 16);
					st_q   <= ST_QSQ;
				end
				ST_QSQ:  st_q <= ST_V1;
				ST_V1:   st_q <= ST_V2;
				ST_V2:   st_q <= ST_V3;
				ST_V3: begin
					var_q   <= var_new;
					count_q <= count_new;
					cnt_q   <= '0;
					if (cfg.warm != 16'd0 && count_new <= {1'b0, cfg.warm}) begin
						// warmup: track the loop bandwidth, keep gathering statistics
						latch_q <= it_q.bw;
						st_q    <= ST_OUT;
					end else begin
						st_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == SQRT_LAST)
						st_q <= ST_DINIT;
				end
				ST_DINIT: begin
					cnt_q <= '0;
					st_q  <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (den_q == 33'd0)
						st_q <= ST_BN;
					else if (cnt_q == DIV_LAST)
						st_q <= ST_BN;
				end
				ST_BN:    st_q <= ST_ARG;
				ST_ARG:   st_q <= ST_SIG;
				ST_SIG:   st_q <= ST_BLEND;
				ST_BLEND: st_q <= ST_GAIN;
				ST_GAIN:  st_q <= ST_CLAMP;
				ST_CLAMP: st_q <= ST_SCHM;
				ST_SCHM: begin
					latch_q <= nxtc[19:0];
					st_q    <= ST_OUT;
				end
				ST_OUT: begin
					if (!oval_q || pop)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// zero spread: quotient stays zero when the divisor is zero
	// (dt_q is cleared in ST_DINIT and no quotient bit is set for a zero divisor)

endmodule

// ===== src/pll_bandwidth_adaptor.sv =====
// Top level of the adaptive PLL loop-bandwidth controller.
//
// Usage:
//   Input words (disc_hz, current_bw, tau_int) enter through push/full; a word is
//   taken on a clock edge with push high and full low. A two-word queue holds them
//   until the sequencer is free.
//   Result words (next_bw, warming_up) leave through empty/pop; the oldest result
//   sits on the ports while empty is low and is taken on an edge with pop high.
//   Configuration registers are written through cfg_valid/cfg_index/cfg_data; the
//   port is always ready. Write them only while no word is in flight.
// Sequencing:
//   Disabled words go straight to the result slot; warmup words stop after the
//   statistics update; adapted words also run the 32-step square root and the 17-step
//   divider (which stops early when mean and spread are both zero). These share one
//   sequencer, so one word is worked on at a time.
// Reset:
//   arst_n clears the statistics, the sample count, the Schmitt latch, the input queue,
//   the result slot and loads the register defaults.
// Stalls:
//   When the receiver does not pop, the finished word waits in the result slot; the
//   sequencer holds its next result and the input queue fills, then full rises.
module pll_bandwidth_adaptor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [23:0] disc_hz,
	input  logic [19:0]        current_bw,
	input  logic [23:0]        tau_int,
	output logic               empty,
	input  logic               pop,
	output logic [19:0]        next_bw,
	output logic               warming_up,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [19:0]        cfg_data
);

	pba_pkg::cfg_t  cfg_q;
	pba_pkg::item_t head;
	logic avail, take, out_valid;

	assign cfg_ready = 1'b1;

	// Register file: decode the index and store the masked word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable <= 1'b0;
			cfg_q.alpha  <= 17'd655;
			cfg_q.tl     <= 17'd32768;
			cfg_q.sgain  <= 20'd1024;
			cfg_q.delta  <= 20'd512;
			cfg_q.bwmin  <= 20'd1024;
			cfg_q.bwmax  <= 20'd51200;
			cfg_q.warm   <= 16'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pba_pkg::REG_ENABLE: cfg_q.enable <= cfg_data[0];
				pba_pkg::REG_ALPHA:  cfg_q.alpha  <= cfg_data[16:0];
				pba_pkg::REG_TLBCA:  cfg_q.tl     <= cfg_data[16:0];
				pba_pkg::REG_SGAIN:  cfg_q.sgain  <= cfg_data;
				pba_pkg::REG_DELTA:  cfg_q.delta  <= cfg_data;
				pba_pkg::REG_BWMIN:  cfg_q.bwmin  <= cfg_data;
				pba_pkg::REG_BWMAX:  cfg_q.bwmax  <= cfg_data;
				pba_pkg::REG_WARM:   cfg_q.warm   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	pba_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.enable     (cfg_q.enable),
		.disc_hz    (disc_hz),
		.current_bw (current_bw),
		.tau_int    (tau_int),
		.take       (take),
		.avail      (avail),
		.head       (head)
	);

	pba_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.avail     (avail),
		.head      (head),
		.take      (take),
		.pop       (pop),
		.out_valid (out_valid),
		.out_bw    (next_bw),
		.out_warm  (warming_up)
	);

	assign empty = !out_valid;

endmodule

// ===== bench/tb_pll_bandwidth_adaptor.sv =====
// Testbench for the adaptive PLL loop-bandwidth controller, with a built-in predictor.
`timescale 1ns / 100ps

module tb_pll_bandwidth_adaptor;

	localparam longint unsigned CYCLE_LIMIT = 4000000;
	localparam int SETTLE_CYCLES = 80;

	typedef struct {
		logic [pba_pkg::BW_W-1:0] bw;
		logic                     wu;
	} bw_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic signed [23:0] disc_hz = '0;
	logic [19:0]        current_bw = '0;
	logic [23:0]        tau_int = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic [19:0]        next_bw;
	logic               warming_up;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [19:0]        cfg_data = '0;

	// Predictor copy of the registers and of the loop statistics.
	logic        m_enable;
	logic [16:0] m_alpha, m_tl;
	logic [19:0] m_sgain, m_delta, m_bwmin, m_bwmax;
	logic [15:0] m_warm;
	longint          m_mean;
	longint unsigned m_var;
	int unsigned     m_count;
	longint          m_latch;

	bw_word_t pending_bw[$];
	int unsigned     mismatches = 0;
	longint unsigned cycles = 0;
	bit              lazy_pop = 1'b0;
	int unsigned     pop_hold = 0;

	pll_bandwidth_adaptor uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.disc_hz(disc_hz), .current_bw(current_bw), .tau_int(tau_int),
		.empty(empty), .pop(pop), .next_bw(next_bw), .warming_up(warming_up),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Hard stop for a hung handshake.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_pll_bandwidth_adaptor NOT OK");
			$finish;
		end
	end

	// ---------------------------------------------------------------- arithmetic
	// floor(a*b/2^16), wraps like a 64-bit product
	function automatic longint unsigned q16_mul(longint unsigned a, longint unsigned b);
		return a * (b >> 16) + ((a * (b & 64'hFFFF)) >> 16);
	endfunction

	// floor(a*d/2^16) for signed d, rounding toward minus infinity
	function automatic longint q16_mul_signed(longint unsigned a, longint d);
		longint unsigned mag, lo, q;
		mag = d < 0 ? 64'd0 - longint'(d) : d;
		lo = a * (mag & 64'hFFFF);
		q = a * (mag >> 16) + (lo >> 16);
		if (d < 0)
			return -longint'(q) - (((lo & 64'hFFFF) != 0) ? 1 : 0);
		return longint'(q);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// Piecewise-linear sigmoid in Q16, mirrored for negative arguments.
	function automatic longint sigmoid_q16(longint x);
		longint y, r;
		y = x < 0 ? -x : x;
		if (y >= 327680)
			r = 65536;
		else if (y >= 155648)
			r = (y >>> 5) + 55296;
		else if (y >= 65536)
			r = (y >>> 3) + 40960;
		else
			r = (y >>> 2) + 32768;
		return x < 0 ? 65536 - r : r;
	endfunction

	function automatic longint clamp_to_limits(longint v);
		if (v > longint'(m_bwmax))
			v = m_bwmax;
		if (v < longint'(m_bwmin))
			v = m_bwmin;
		return v;
	endfunction

	// Advance the loop statistics and return the bandwidth word this sample yields.
	function automatic bw_word_t next_bandwidth(logic signed [23:0] disc, logic [19:0] bw,
		logic [23:0] tau);
		bw_word_t        w;
		longint          dev, a1, a2, s1, s2, g, sd, bhat, diff, nxt;
		longint unsigned alpha, tl, q, sig, m, den, dt, p, blend;
		alpha = m_alpha > pba_pkg::Q16_ONE ? 65536 : m_alpha;
		tl = m_tl > pba_pkg::Q16_ONE ? 65536 : m_tl;
		w.bw = bw;
		w.wu = 1'b1;
		if (!m_enable)
			return w;
		dev = longint'(disc) * 65536 - m_mean;
		m_mean = m_mean + q16_mul_signed(alpha, dev);
		q = (dev < 0 ? 64'd0 - longint'(dev) : dev) >> 8;
		if (q > 64'hFFFF_FFFF)
			q = 64'hFFFF_FFFF;
		m_var = q16_mul(alpha, q * q) + q16_mul(65536 - alpha, m_var);
		if (m_count < 131071)
			m_count++;
		if (m_warm > 0 && m_count <= m_warm) begin
			m_latch = bw;
			return w;
		end
		sig = int_sqrt(m_var);
		m = (m_mean < 0 ? 64'd0 - longint'(m_mean) : m_mean) >> 8;
		den = sig + m;
		dt = den == 0 ? 0 : (m << 16) / den;
		p = longint'(bw) * longint'(tau);
		a1 = longint'((50 * p) >> 18) - 3 * 65536;
		a2 = longint'((250 * p) >> 18) - 90 * 65536;
		s1 = sigmoid_q16(a1);
		s2 = sigmoid_q16(a2);
		blend = (tl * longint'(s1) + (65536 - tl) * longint'(s2)) >> 16;
		g = longint'((longint'(m_sgain) * blend) >> 16);
		sd = longint'((longint'(m_sgain) * dt) >> 16);
		bhat = clamp_to_limits(longint'(bw) + sd - g);
		diff = bhat - m_latch;
		nxt = m_latch;
		if (diff > longint'(m_delta))
			nxt = m_latch + m_delta;
		else if (diff < -longint'(m_delta))
			nxt = m_latch - m_delta;
		nxt = clamp_to_limits(nxt);
		m_latch = nxt;
		w.bw = nxt[19:0];
		w.wu = 1'b0;
		return w;
	endfunction

	// ---------------------------------------------------------------- result side
	// Stall pop at random: mostly short holds, now and then a long one.
	always @(posedge clk) begin
		if (pop_hold > 0) begin
			pop_hold <= pop_hold - 1;
			pop <= 1'b0;
		end else if (lazy_pop && $urandom_range(0, 99) < 4) begin
			pop_hold <= $urandom_range(10, 80);
			pop <= 1'b0;
		end else begin
			pop <= !lazy_pop || ($urandom_range(0, 3) != 0);
		end
	end

	// Compare every popped word against the oldest prediction.
	always @(posedge clk) begin
		bw_word_t want;
		if (arst_n && pop && !empty) begin
			if (pending_bw.size() == 0) begin
				$error("unexpected word: next_bw=%0d warming_up=%0b", next_bw, warming_up);
				mismatches++;
			end else begin
				want = pending_bw.pop_front();
				if (next_bw !== want.bw) begin
					$error("next_bw: expected %0d, got %0d", want.bw, next_bw);
					mismatches++;
				end
				if (warming_up !== want.wu) begin
					$error("warming_up: expected %0b, got %0b", want.wu, warming_up);
					mismatches++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- drivers
	// Push one word after a random gap; predict once the block takes it.
	task automatic send_word(logic signed [23:0] disc, logic [19:0] bw, logic [23:0] tau);
		int unsigned gap, roll;
		roll = $urandom_range(0, 99);
		gap = roll < 60 ? 0 : roll < 92 ? $urandom_range(1, 3) : $urandom_range(10, 60);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		disc_hz <= disc;
		current_bw <= bw;
		tau_int <= tau;
		@(posedge clk);
		while (full)
			@(posedge clk);
		pending_bw.push_back(next_bandwidth(disc, bw, tau));
	endtask

	// Hold off the sender until every predicted word has been popped.
	task automatic drain();
		push <= 1'b0;
		while (pending_bw.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [19:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			pba_pkg::REG_ENABLE: m_enable = value[0];
			pba_pkg::REG_ALPHA:  m_alpha = value[16:0];
			pba_pkg::REG_TLBCA:  m_tl = value[16:0];
			pba_pkg::REG_SGAIN:  m_sgain = value;
			pba_pkg::REG_DELTA:  m_delta = value;
			pba_pkg::REG_BWMIN:  m_bwmin = value;
			pba_pkg::REG_BWMAX:  m_bwmax = value;
			pba_pkg::REG_WARM:   m_warm = value[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Wide spread of magnitudes so small and full-scale values both show up.
	function automatic logic [23:0] spread24();
		return 24'($urandom() >> (8 + $urandom_range(0, 23)));
	endfunction

	function automatic logic signed [23:0] rand_disc();
		logic signed [23:0] d;
		d = spread24();
		return $urandom_range(0, 1) ? -d : d;
	endfunction

	// ---------------------------------------------------------------- tests
	// Reset state: disabled, so every word passes through.
	task automatic test_passthrough();
		send_word(24'sh7FFFFF, 20'hFFFFF, 24'hFFFFFF);
		send_word(24'sh800000, 20'h00000, 24'h000000);
		send_word(24'sh000000, 20'h12345, 24'hABCDEF);
		drain();
	endtask

	// Edge settings of every register and the named corner cases.
	task automatic test_directed();
		write_reg(pba_pkg::REG_ENABLE, 20'd1);
		write_reg(pba_pkg::REG_WARM, 20'd0);
		send_word(24'sd0, 20'd10240, 24'd16777);   // zero spread: mean and sigma both zero
		send_word(24'sh7FFFFF, 20'hFFFFF, 24'hFFFFFF);
		send_word(24'sh800000, 20'd0, 24'd0);
		send_word(24'sh7FFFFF, 20'd51200, 24'd1);
		drain();
		write_reg(pba_pkg::REG_ALPHA, 20'd65536);  // alpha of one
		write_reg(pba_pkg::REG_TLBCA, 20'd0);
		write_reg(pba_pkg::REG_SGAIN, 20'hFFFFF);
		write_reg(pba_pkg::REG_DELTA, 20'hFFFFF);
		write_reg(pba_pkg::REG_BWMIN, 20'd0);
		write_reg(pba_pkg::REG_BWMAX, 20'hFFFFF);
		send_word(24'sh400000, 20'd500000, 24'd100000);
		send_word(-24'sd1, 20'd3000, 24'd8000000);
		send_word(24'sd1, 20'd0, 24'hFFFFFF);
		drain();
		write_reg(pba_pkg::REG_ALPHA, 20'h1FFFF);  // above one, saturates
		write_reg(pba_pkg::REG_TLBCA, 20'h1FFFF);
		write_reg(pba_pkg::REG_DELTA, 20'd0);
		send_word(24'sh123456, 20'd40000, 24'd20000);
		send_word(-24'sh123456, 20'd40000, 24'd20000);
		drain();
		write_reg(pba_pkg::REG_ALPHA, 20'd0);
		write_reg(pba_pkg::REG_DELTA, 20'd300);
		write_reg(pba_pkg::REG_BWMIN, 20'd60000);  // crossed limits
		write_reg(pba_pkg::REG_BWMAX, 20'd2000);
		send_word(24'sh00F000, 20'd30000, 24'd50000);
		send_word(24'sh800000, 20'd1, 24'd1);
		drain();
		write_reg(pba_pkg::REG_BWMIN, 20'd1024);
		write_reg(pba_pkg::REG_BWMAX, 20'd51200);
		write_reg(pba_pkg::REG_ALPHA, 20'd655);
		write_reg(pba_pkg::REG_WARM, 20'hFFFF);    // long warmup
		send_word(24'sh000800, 20'd7000, 24'd16777);
		send_word(24'sh7FF000, 20'd9000, 24'd33554);
		drain();
		write_reg(pba_pkg::REG_WARM, 20'd3);
		send_word(24'sh001000, 20'd7000, 24'd16777);
		drain();
	endtask

	// One random setting per phase, extremes mixed in.
	task automatic pick_setting();
		logic [19:0] lo, hi;
		int unsigned roll;
		roll = $urandom_range(0, 9);
		write_reg(pba_pkg::REG_ENABLE, 20'(roll != 0));
		case ($urandom_range(0, 4))
			0: write_reg(pba_pkg::REG_ALPHA, 20'd0);
			1: write_reg(pba_pkg::REG_ALPHA, 20'd65536);
			2: write_reg(pba_pkg::REG_ALPHA, 20'($urandom_range(65537, 131071)));
			default: write_reg(pba_pkg::REG_ALPHA, 20'($urandom_range(1, 65535)));
		endcase
		write_reg(pba_pkg::REG_TLBCA, $urandom_range(0, 4) == 0
			? 20'($urandom_range(65536, 131071)) : 20'($urandom_range(0, 65536)));
		write_reg(pba_pkg::REG_SGAIN, 20'($urandom() >> (12 + $urandom_range(0, 20))));
		write_reg(pba_pkg::REG_DELTA, 20'($urandom() >> (12 + $urandom_range(0, 20))));
		lo = 20'($urandom() >> (12 + $urandom_range(0, 20)));
		hi = 20'($urandom() >> (12 + $urandom_range(0, 20)));
		if ($urandom_range(0, 4) != 0 && lo > hi) begin
			write_reg(pba_pkg::REG_BWMIN, hi);
			write_reg(pba_pkg::REG_BWMAX, lo);
		end else begin
			write_reg(pba_pkg::REG_BWMIN, lo);
			write_reg(pba_pkg::REG_BWMAX, hi);
		end
		write_reg(pba_pkg::REG_WARM, $urandom_range(0, 5) == 0
			? 20'($urandom_range(0, 65535)) : 20'(m_count + $urandom_range(0, 20)));
	endtask

	// Random tracking runs: a bias plus noise, so the statistics settle and move.
	task automatic test_random(int unsigned words);
		int unsigned sent, run, i;
		logic signed [23:0] bias;
		logic [19:0] bw;
		logic [23:0] tau;
		sent = 0;
		while (sent < words) begin
			drain();
			pick_setting();
			lazy_pop = $urandom_range(0, 3) != 0;
			run = $urandom_range(20, 120);
			bias = rand_disc();
			bw = 20'($urandom() >> (12 + $urandom_range(0, 12)));
			tau = 24'($urandom() >> (8 + $urandom_range(0, 16)));
			for (i = 0; i < run; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_word(rand_disc(), 20'($urandom()), 24'($urandom()));
				else
					send_word(bias + (rand_disc() >>> $urandom_range(0, 12)), bw, tau);
			end
			sent += run;
		end
		drain();
	endtask

	initial begin
		m_enable = 1'b0;
		m_alpha = 17'd655;
		m_tl = 17'd32768;
		m_sgain = 20'd1024;
		m_delta = 20'd512;
		m_bwmin = 20'd1024;
		m_bwmax = 20'd51200;
		m_warm = 16'd0;
		m_mean = 0;
		m_var = 0;
		m_count = 0;
		m_latch = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_passthrough();
		test_directed();
		test_random(2000);
		if (mismatches == 0)
			$display("tb_pll_bandwidth_adaptor OK");
		else
			$display("tb_pll_bandwidth_adaptor NOT OK");
		$finish;
	end

endmodule

// ===== pll_bandwidth_adaptor.f =====
src/pba_pkg.sv
src/pba_front.sv
src/pba_back.sv
src/pll_bandwidth_adaptor.sv
bench/tb_pll_bandwidth_adaptor.sv
